/* design/klm_pkg.sv */
// Shared constants, types and codes of the keypad code lock matcher.
`default_nettype none

package klm_pkg;

    // Table and code geometry.
    localparam int USER_SLOTS  = 10;
    localparam int CODE_DIGITS = 8;
    localparam int NEW_DIGITS  = 8;
    localparam int CODE_W      = 4 * CODE_DIGITS;
    localparam int CNT_W       = $clog2(CODE_DIGITS + 1);
    localparam int SLOT_IDX_W  = $clog2(USER_SLOTS);

    // Field widths of the channels and the register.
    localparam int REQ_W     = 2;
    localparam int KEY_W     = 4;
    localparam int SLOT_W    = 4;
    localparam int NEWCODE_W = 32;
    localparam int LEN_W     = 4;
    localparam int VERD_W    = 3;
    localparam int CFG_W     = 4;
    localparam int LIM_W     = (CFG_W > CNT_W) ? CFG_W : CNT_W;

    // Reset contents of the admin slot and of max_digits.
    localparam logic [CODE_W-1:0] ADMIN_CODE  = CODE_W'(32'h1234_5678);
    localparam logic [CNT_W-1:0]  ADMIN_COUNT = CNT_W'(8);
    localparam logic [CFG_W-1:0]  MAX_DIGITS_RESET = CFG_W'(8);

    // Request types.
    localparam logic [REQ_W-1:0] REQ_KEY     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_REPLACE = 2'd3;

    // Key codes.
    localparam logic [KEY_W-1:0] KEY_LAST_DIGIT = 4'd9;
    localparam logic [KEY_W-1:0] KEY_STAR       = 4'd10;
    localparam logic [KEY_W-1:0] KEY_HASH       = 4'd11;

    // Verdict codes.
    localparam logic [VERD_W-1:0] V_REJECT = 3'd0;
    localparam logic [VERD_W-1:0] V_ADMIN  = 3'd1;
    localparam logic [VERD_W-1:0] V_USER   = 3'd2;
    localparam logic [VERD_W-1:0] V_DONE   = 3'd3;
    localparam logic [VERD_W-1:0] V_FAIL   = 3'd4;

    // One entry of the code table; a count of zero marks an empty slot.
    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [CODE_W-1:0] digits;
    } code_slot_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TABLE,
        ST_EMIT
    } klm_state_t;

    // Contents of a slot that has not been written since reset.
    function automatic code_slot_t slot_reset_value(input logic [SLOT_IDX_W-1:0] idx);
        code_slot_t v;
        v.count  = '0;
        v.digits = '0;
        if (idx == '0)
        begin
            v.count  = ADMIN_COUNT;
            v.digits = ADMIN_CODE;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* design/klm_req_if.sv */
// Request channel of the keypad code lock matcher.
`default_nettype none

interface klm_req_if import klm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [KEY_W-1:0]     key_code;
    logic [SLOT_W-1:0]    slot;
    logic [NEWCODE_W-1:0] new_code;
    logic [LEN_W-1:0]     new_length;

    modport source (output valid, req_type, key_code, slot, new_code, new_length,
                    input ready);
    modport sink (input valid, req_type, key_code, slot, new_code, new_length,
                  output ready);
endinterface

`default_nettype wire

/* design/klm_rsp_if.sv */
// Result channel of the keypad code lock matcher.
`default_nettype none

interface klm_rsp_if import klm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [VERD_W-1:0] verdict;
    logic [SLOT_W-1:0] matched_slot;

    modport source (output valid, verdict, matched_slot, input ready);
    modport sink (input valid, verdict, matched_slot, output ready);
endinterface

`default_nettype wire

/* design/keypad_code_lock_matcher.sv */
// Top level of the keypad code lock matcher: entry buffer, code table memory and controller.
`default_nettype none

// Keypad code lock. Digit, star and ignored keys are taken while idle and give
// no result. A hash walks the code table in its synchronous memory (one write
// port, one registered read port), one slot per cycle, and stops at the first
// match or after the last of the USER_SLOTS slots.
// A table request reads its slot, then writes it unless an add finds the slot
// occupied; a request with a slot out of range, or an add or replace with a bad
// length, fails without writing the table. Results go through an output
// register, so a new request is taken while a result waits; a request that
// would give a result holds in its last cycle until that register is free.
// Slots not written since reset read as their reset contents through per-slot
// valid flip-flops, so no clearing pass follows reset. max_digits is to be
// written only while the block is idle; the block itself does not enforce this.
module keypad_code_lock_matcher import klm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_data,
    klm_req_if.sink               req,
    klm_rsp_if.source             rsp
);

    // Controller and entry state.
    klm_state_t            state_reg, state_next;
    logic [SLOT_IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [CODE_W-1:0]     entry_digits_reg, entry_digits_next;
    logic [CNT_W-1:0]      entry_count_reg, entry_count_next;
    logic [CFG_W-1:0]      max_digits_reg;

    // Latched table request.
    logic [REQ_W-1:0]      op_type_reg, op_type_next;
    logic [SLOT_IDX_W-1:0] op_slot_reg, op_slot_next;
    logic [NEWCODE_W-1:0]  op_code_reg, op_code_next;
    logic [LEN_W-1:0]      op_len_reg, op_len_next;

    // Pending result and output register.
    logic [VERD_W-1:0]     res_verdict_reg, res_verdict_next;
    logic [SLOT_W-1:0]     res_slot_reg, res_slot_next;
    logic                  out_valid_reg, out_valid_next;
    logic [VERD_W-1:0]     out_verdict_reg, out_verdict_next;
    logic [SLOT_W-1:0]     out_slot_reg, out_slot_next;

    // Code table memory and its per-slot written flags.
    code_slot_t            code_mem [USER_SLOTS];
    logic [USER_SLOTS-1:0] slot_valid_reg;
    code_slot_t            rd_data_reg;
    logic                  rd_vld_reg;
    logic [SLOT_IDX_W-1:0] rd_addr_reg;

    // Handshake and memory control.
    logic                  req_fire;
    logic                  rsp_load;
    logic [SLOT_IDX_W-1:0] rd_addr_raw;
    logic [SLOT_IDX_W-1:0] rd_addr;
    logic                  mem_we;
    code_slot_t            mem_wd;

    // Decoded request and table entry.
    code_slot_t            rd_slot;
    logic                  slot_match;
    logic                  slot_oor;
    logic                  len_ok;
    logic                  is_digit;
    logic [LIM_W-1:0]      digit_lim;
    logic [NEWCODE_W-1:0]  code_aligned;

    assign req_fire = req.valid && req.ready;

    // Effective limit on the number of entered digits.
    always_comb
    begin
        digit_lim = LIM_W'(max_digits_reg);
        if (digit_lim == '0)
        begin
            digit_lim = LIM_W'(1);
        end
        else if (digit_lim > LIM_W'(CODE_DIGITS))
        begin
            digit_lim = LIM_W'(CODE_DIGITS);
        end
    end

    // Request decode.
    assign is_digit = (req.key_code <= KEY_LAST_DIGIT);
    assign slot_oor = ({1'b0, req.slot} >= (SLOT_W + 1)'(USER_SLOTS));
    assign len_ok   = (req.new_length != '0) &&
                      (req.new_length <= LEN_W'(NEW_DIGITS)) &&
                      ({1'b0, req.new_length} <= (LEN_W + 1)'(CODE_DIGITS));

    // Slot contents as read; unwritten slots show their reset value.
    assign rd_slot    = rd_vld_reg ? rd_data_reg : slot_reset_value(rd_addr_reg);
    assign slot_match = (rd_slot.count != '0) &&
                        (rd_slot.count == entry_count_reg) &&
                        (rd_slot.digits == entry_digits_reg);

    // Stored form of a new code: the valid digits right-aligned.
    assign code_aligned = op_code_reg >> {(LEN_W'(NEW_DIGITS) - op_len_reg), 2'b00};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.req_type == REQ_KEY)
                    begin
                        if (req.key_code == KEY_HASH)
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else if (slot_oor)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (req.req_type != REQ_DELETE && !len_ok)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_TABLE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (slot_match || scan_idx_reg == SLOT_IDX_W'(USER_SLOTS - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_TABLE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller outputs: handshake, memory read address and write port.
    always_comb
    begin
        req.ready   = 1'b0;
        rsp_load    = 1'b0;
        rd_addr_raw = '0;
        mem_we      = 1'b0;
        mem_wd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.req_type != REQ_KEY)
                begin
                    rd_addr_raw = req.slot[SLOT_IDX_W-1:0];
                end
            end
            ST_SCAN:
            begin
                rd_addr_raw = scan_idx_reg + SLOT_IDX_W'(1);
            end
            ST_TABLE:
            begin
                if (op_type_reg == REQ_DELETE)
                begin
                    mem_we = 1'b1;
                end
                else if (op_type_reg == REQ_REPLACE || rd_slot.count == '0)
                begin
                    mem_we        = 1'b1;
                    mem_wd.count  = CNT_W'(op_len_reg);
                    mem_wd.digits = CODE_W'(code_aligned);
                end
            end
            ST_EMIT:
            begin
                rsp_load = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // Keep the read address inside the table.
    assign rd_addr = ({1'b0, rd_addr_raw} < (SLOT_IDX_W + 1)'(USER_SLOTS)) ? rd_addr_raw : '0;

    // Datapath next values.
    always_comb
    begin
        scan_idx_next     = scan_idx_reg;
        entry_digits_next = entry_digits_reg;
        entry_count_next  = entry_count_reg;
        op_type_next      = op_type_reg;
        op_slot_next      = op_slot_reg;
        op_code_next      = op_code_reg;
        op_len_next       = op_len_reg;
        res_verdict_next  = res_verdict_reg;
        res_slot_next     = res_slot_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    op_type_next     = req.req_type;
                    op_slot_next     = req.slot[SLOT_IDX_W-1:0];
                    op_code_next     = req.new_code;
                    op_len_next      = req.new_length;
                    res_verdict_next = V_FAIL;
                    res_slot_next    = '0;
                    scan_idx_next    = '0;
                    if (req.req_type == REQ_KEY)
                    begin
                        if (is_digit)
                        begin
                            if (LIM_W'(entry_count_reg) < digit_lim)
                            begin
                                entry_digits_next = {entry_digits_reg[CODE_W-5:0],
                                                     req.key_code};
                                entry_count_next  = entry_count_reg + CNT_W'(1);
                            end
                        end
                        else if (req.key_code == KEY_STAR)
                        begin
                            entry_digits_next = '0;
                            entry_count_next  = '0;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                scan_idx_next = scan_idx_reg + SLOT_IDX_W'(1);
                if (slot_match)
                begin
                    res_verdict_next = (scan_idx_reg == '0) ? V_ADMIN : V_USER;
                    res_slot_next    = SLOT_W'(scan_idx_reg);
                end
                else
                begin
                    res_verdict_next = V_REJECT;
                    res_slot_next    = '0;
                end
                if (slot_match || scan_idx_reg == SLOT_IDX_W'(USER_SLOTS - 1))
                begin
                    entry_digits_next = '0;
                    entry_count_next  = '0;
                end
            end
            ST_TABLE:
            begin
                res_verdict_next = mem_we ? V_DONE : V_FAIL;
                res_slot_next    = '0;
            end
            ST_EMIT:
            begin
                res_slot_next = res_slot_reg;
            end
            default:
            begin
                scan_idx_next = '0;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_verdict_next = out_verdict_reg;
        out_slot_next    = out_slot_reg;
        if (rsp_load)
        begin
            out_valid_next   = 1'b1;
            out_verdict_next = res_verdict_reg;
            out_slot_next    = res_slot_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.verdict      = out_verdict_reg;
    assign rsp.matched_slot = out_slot_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            scan_idx_reg     <= '0;
            entry_digits_reg <= '0;
            entry_count_reg  <= '0;
            max_digits_reg   <= MAX_DIGITS_RESET;
            out_valid_reg    <= 1'b0;
            slot_valid_reg   <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            scan_idx_reg     <= scan_idx_next;
            entry_digits_reg <= entry_digits_next;
            entry_count_reg  <= entry_count_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_we)
            begin
                max_digits_reg <= cfg_data;
            end
            if (mem_we)
            begin
                slot_valid_reg[op_slot_reg] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_type_reg     <= op_type_next;
        op_slot_reg     <= op_slot_next;
        op_code_reg     <= op_code_next;
        op_len_reg      <= op_len_next;
        res_verdict_reg <= res_verdict_next;
        res_slot_reg    <= res_slot_next;
        out_verdict_reg <= out_verdict_next;
        out_slot_reg    <= out_slot_next;
    end

    // Code table memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            code_mem[op_slot_reg] <= mem_wd;
        end
        rd_data_reg <= code_mem[rd_addr];
        rd_vld_reg  <= slot_valid_reg[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    // The entry never holds more digits than a code can have.
    assert property (@(posedge clk) disable iff (!rst_n)
        LIM_W'(entry_count_reg) <= LIM_W'(CODE_DIGITS))
        else $error("entry count above code length");

    // Table requests leave the entry untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.req_type != REQ_KEY) |=> $stable(entry_count_reg))
        else $error("table request changed the entry");

    // Only a user grant carries a nonzero slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.verdict != V_USER) |-> (rsp.matched_slot == '0))
        else $error("nonzero slot on a result that is not a user grant");

    // The table is written only in the cycle after its slot was read.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (rd_addr_reg == op_slot_reg && $past(state_reg) == ST_IDLE))
        else $error("table write without a preceding read of its slot");

endmodule

`default_nettype wire
